// ===== design/top_k_frequency_heap_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the top-k frequency heap unit
// Shared property templates, clocked on clk and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef TOP_K_FREQUENCY_HEAP_UNIT_ASSERT_SVH
`define TOP_K_FREQUENCY_HEAP_UNIT_ASSERT_SVH

// Same-cycle implication
`define TKH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("top_k_frequency_heap_unit: same-cycle check failed");

// Next-cycle implication
`define TKH_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("top_k_frequency_heap_unit: next-cycle check failed");

`endif

// ===== design/tkfh_pkg.sv =====
// ----------------------------------------------------------------------------
// tkfh_pkg
// Sizes and the heap entry type of the top-k frequency heap unit.
// ----------------------------------------------------------------------------
package tkfh_pkg;

  localparam int MAX_ENTRIES = 32;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int KEY_W       = 64;
  localparam int COUNT_W     = 32;
  localparam int SLOT_W      = 6;
  localparam int CFG_W       = 6;
  localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(32);

  localparam logic REQ_COUNT = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;
  localparam logic KIND_SLOT = 1'b0;
  localparam logic KIND_RANK = 1'b1;

  typedef struct packed {
    logic [COUNT_W-1:0] cnt;
    logic [KEY_W-1:0]   key;
  } entry_t;

endpackage

// ===== design/top_k_frequency_heap_unit.sv =====
// ----------------------------------------------------------------------------
// top_k_frequency_heap_unit
// Min-heap of the most frequent words, one shared compare unit and one
// single-port-write heap memory under a small sequencer.
// ----------------------------------------------------------------------------
// Channel   Handshake              Payload
// request   start / busy           in_req_type in_word_key in_word_count in_held_slot
// result    out_valid (strobe)     out_result_kind out_key out_slot out_count out_last
// config    cfg_we                 cfg_data (capacity)
//
// A count request keeps busy while it walks the heap: each level sifted up fetches
// the parent and then decides (ST_UP_RD, ST_UP_DEC), each level sifted down fetches
// the left child, then the right child, then decides (ST_DN_RL, ST_DN_RR, ST_DN_DEC);
// a held word is first loaded and a full heap first tests its root. The memory read
// port, one access a cycle, sets this. A drain is a selection scan, one read per
// compare. Results come one a cycle at most and cannot be stalled. Reset (rst_n low,
// synchronous) empties the heap and sets capacity to 32; no clearing pass is needed.
// ----------------------------------------------------------------------------
module top_k_frequency_heap_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_req_type,
  input  logic [tkfh_pkg::KEY_W-1:0]    in_word_key,
  input  logic [tkfh_pkg::COUNT_W-1:0]  in_word_count,
  input  logic signed [tkfh_pkg::SLOT_W-1:0] in_held_slot,
  output logic                          out_valid,
  output logic                          out_result_kind,
  output logic [tkfh_pkg::KEY_W-1:0]    out_key,
  output logic signed [tkfh_pkg::SLOT_W-1:0] out_slot,
  output logic [tkfh_pkg::COUNT_W-1:0]  out_count,
  output logic                          out_last,
  input  logic                          cfg_we,
  input  logic [tkfh_pkg::CFG_W-1:0]    cfg_data
);

  localparam int IW = tkfh_pkg::IDX_W;
  localparam int CW = tkfh_pkg::CNT_W;
  localparam int SW = tkfh_pkg::SLOT_W;
  localparam int LW = tkfh_pkg::IDX_W + 2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LD_HELD, ST_FULL_CHK, ST_UP_RD, ST_UP_DEC,
    ST_DN_RL, ST_DN_RR, ST_DN_DEC,
    ST_DR_RI, ST_DR_LI, ST_DR_SCAN, ST_DR_CMP, ST_DR_SW, ST_DR_W2
  } state_t;

  state_t                    state_r, state_nxt;
  logic [IW-1:0]             p_r, p_nxt;
  logic [CW-1:0]             n_r, n_nxt;
  logic [tkfh_pkg::CFG_W-1:0] cap_r;
  tkfh_pkg::entry_t          item_r, item_nxt;
  tkfh_pkg::entry_t          best_r, best_nxt;
  tkfh_pkg::entry_t          idata_r, idata_nxt;
  logic [IW-1:0]             bidx_r, bidx_nxt;
  logic                      bhas_r, bhas_nxt;
  logic [CW-1:0]             i_r, i_nxt, j_r, j_nxt;

  logic                      ov_r, ov_nxt, ok_r, ok_nxt, ol_r, ol_nxt;
  logic [tkfh_pkg::KEY_W-1:0]   okey_r, okey_nxt;
  logic [SW-1:0]             oslot_r, oslot_nxt;
  logic [tkfh_pkg::COUNT_W-1:0] ocnt_r, ocnt_nxt;

  // heap memory
  tkfh_pkg::entry_t          mem [tkfh_pkg::MAX_ENTRIES];
  tkfh_pkg::entry_t          rd_data_r, mem_wd;
  logic [IW-1:0]             mem_ra, mem_wa;
  logic                      mem_we;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  // shared compare unit: a nearer the root than b
  tkfh_pkg::entry_t cmp_a, cmp_b;
  logic             cmp_lt;
  assign cmp_lt = (cmp_a.cnt != cmp_b.cnt) ? (cmp_a.cnt < cmp_b.cnt)
                                           : (cmp_a.key > cmp_b.key);

  // heap geometry around the current slot
  logic [LW-1:0] l_idx, r_idx;
  logic          l_in, r_in;
  assign l_idx = {1'b0, p_r, 1'b1};
  assign r_idx = l_idx + LW'(1);
  assign l_in  = l_idx < LW'(n_r);
  assign r_in  = r_idx < LW'(n_r);

  // effective capacity and request decode
  logic [31:0] cap_eff;
  logic        full, held;
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = 32'd1;
    end else if (32'(cap_r) > tkfh_pkg::MAX_ENTRIES) begin
      cap_eff = 32'(tkfh_pkg::MAX_ENTRIES);
    end else begin
      cap_eff = 32'(cap_r);
    end
  end
  assign full = 32'(n_r) >= cap_eff;
  assign held = !in_held_slot[SW-1] && (CW'(in_held_slot[SW-2:0]) < n_r);
  assign busy = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    p_nxt     = p_r;
    n_nxt     = n_r;
    item_nxt  = item_r;
    best_nxt  = best_r;
    idata_nxt = idata_r;
    bidx_nxt  = bidx_r;
    bhas_nxt  = bhas_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    ov_nxt    = 1'b0;
    ok_nxt    = tkfh_pkg::KIND_SLOT;
    ol_nxt    = 1'b0;
    okey_nxt  = okey_r;
    oslot_nxt = oslot_r;
    ocnt_nxt  = ocnt_r;
    mem_ra    = p_r;
    mem_we    = 1'b0;
    mem_wa    = p_r;
    mem_wd    = item_r;
    cmp_a     = item_r;
    cmp_b     = item_r;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_req_type == tkfh_pkg::REQ_DRAIN) begin
            i_nxt = '0;
            if (n_r != '0) begin
              state_nxt = ST_DR_RI;
            end
          end else if (held) begin
            mem_ra    = IW'(in_held_slot[SW-2:0]);
            p_nxt     = IW'(in_held_slot[SW-2:0]);
            state_nxt = ST_LD_HELD;
          end else begin
            item_nxt.cnt = in_word_count;
            item_nxt.key = in_word_key;
            if (!full) begin
              p_nxt     = IW'(n_r);
              n_nxt     = n_r + CW'(1);
              state_nxt = ST_UP_RD;
            end else begin
              mem_ra    = '0;
              state_nxt = ST_FULL_CHK;
            end
          end
        end
      end

      // held word: bump count, saturating, then sift down
      ST_LD_HELD: begin
        item_nxt = rd_data_r;
        if (rd_data_r.cnt != '1) begin
          item_nxt.cnt = rd_data_r.cnt + tkfh_pkg::COUNT_W'(1);
        end
        state_nxt = ST_DN_RL;
      end

      // full heap: does the word beat the root
      ST_FULL_CHK: begin
        cmp_a = rd_data_r;
        cmp_b = item_r;
        ov_nxt = 1'b1;
        if (cmp_lt) begin
          okey_nxt  = rd_data_r.key;
          oslot_nxt = '1;
          ocnt_nxt  = rd_data_r.cnt;
          p_nxt     = '0;
          state_nxt = ST_DN_RL;
        end else begin
          okey_nxt  = item_r.key;
          oslot_nxt = '1;
          ocnt_nxt  = '0;
          ol_nxt    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      // sift up: fetch parent
      ST_UP_RD: begin
        if (p_r == '0) begin
          mem_we    = 1'b1;
          ov_nxt    = 1'b1;
          ol_nxt    = 1'b1;
          okey_nxt  = item_r.key;
          oslot_nxt = SW'(p_r);
          ocnt_nxt  = item_r.cnt;
          state_nxt = ST_IDLE;
        end else begin
          mem_ra    = IW'((p_r - IW'(1)) >> 1);
          state_nxt = ST_UP_DEC;
        end
      end

      ST_UP_DEC: begin
        cmp_a  = item_r;
        cmp_b  = rd_data_r;
        mem_we = 1'b1;
        ov_nxt = 1'b1;
        if (cmp_lt) begin
          mem_wd    = rd_data_r;
          okey_nxt  = rd_data_r.key;
          oslot_nxt = SW'(p_r);
          ocnt_nxt  = rd_data_r.cnt;
          p_nxt     = IW'((p_r - IW'(1)) >> 1);
          state_nxt = ST_UP_RD;
        end else begin
          okey_nxt  = item_r.key;
          oslot_nxt = SW'(p_r);
          ocnt_nxt  = item_r.cnt;
          ol_nxt    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      // sift down: fetch left child or settle
      ST_DN_RL: begin
        if (!l_in) begin
          mem_we    = 1'b1;
          ov_nxt    = 1'b1;
          ol_nxt    = 1'b1;
          okey_nxt  = item_r.key;
          oslot_nxt = SW'(p_r);
          ocnt_nxt  = item_r.cnt;
          state_nxt = ST_IDLE;
        end else begin
          mem_ra    = IW'(l_idx);
          state_nxt = ST_DN_RR;
        end
      end

      // compare left child, fetch right child
      ST_DN_RR: begin
        cmp_a  = rd_data_r;
        cmp_b  = item_r;
        mem_ra = IW'(r_idx);
        bidx_nxt = IW'(l_idx);
        if (cmp_lt) begin
          best_nxt = rd_data_r;
          bhas_nxt = 1'b1;
        end else begin
          best_nxt = item_r;
          bhas_nxt = 1'b0;
        end
        state_nxt = ST_DN_DEC;
      end

      ST_DN_DEC: begin
        cmp_a = rd_data_r;
        cmp_b = best_r;
        if (r_in && cmp_lt) begin
          mem_we    = 1'b1;
          mem_wd    = rd_data_r;
          ov_nxt    = 1'b1;
          okey_nxt  = rd_data_r.key;
          oslot_nxt = SW'(p_r);
          ocnt_nxt  = rd_data_r.cnt;
          p_nxt     = IW'(r_idx);
          state_nxt = ST_DN_RL;
        end else if (bhas_r) begin
          mem_we    = 1'b1;
          mem_wd    = best_r;
          ov_nxt    = 1'b1;
          okey_nxt  = best_r.key;
          oslot_nxt = SW'(p_r);
          ocnt_nxt  = best_r.cnt;
          p_nxt     = bidx_r;
          state_nxt = ST_DN_RL;
        end else begin
          mem_we    = 1'b1;
          ov_nxt    = 1'b1;
          ol_nxt    = 1'b1;
          okey_nxt  = item_r.key;
          oslot_nxt = SW'(p_r);
          ocnt_nxt  = item_r.cnt;
          state_nxt = ST_IDLE;
        end
      end

      // drain: selection of the best remaining entry for rank i
      ST_DR_RI: begin
        mem_ra    = IW'(i_r);
        state_nxt = ST_DR_LI;
      end

      ST_DR_LI: begin
        idata_nxt = rd_data_r;
        best_nxt  = rd_data_r;
        bidx_nxt  = IW'(i_r);
        j_nxt     = i_r + CW'(1);
        state_nxt = ST_DR_SCAN;
      end

      ST_DR_SCAN: begin
        if (j_r < n_r) begin
          mem_ra    = IW'(j_r);
          state_nxt = ST_DR_CMP;
        end else begin
          state_nxt = ST_DR_SW;
        end
      end

      ST_DR_CMP: begin
        cmp_a = best_r;
        cmp_b = rd_data_r;
        if (cmp_lt) begin
          best_nxt = rd_data_r;
          bidx_nxt = IW'(j_r);
        end
        j_nxt     = j_r + CW'(1);
        state_nxt = ST_DR_SCAN;
      end

      // swap, first half, and emit the ranked entry
      ST_DR_SW: begin
        mem_we    = 1'b1;
        mem_wa    = bidx_r;
        mem_wd    = idata_r;
        ov_nxt    = 1'b1;
        ok_nxt    = tkfh_pkg::KIND_RANK;
        okey_nxt  = best_r.key;
        oslot_nxt = '1;
        ocnt_nxt  = best_r.cnt;
        ol_nxt    = (i_r == n_r - CW'(1));
        state_nxt = ST_DR_W2;
      end

      ST_DR_W2: begin
        mem_we = 1'b1;
        mem_wa = IW'(i_r);
        mem_wd = best_r;
        if (i_r == n_r - CW'(1)) begin
          n_nxt     = '0;
          state_nxt = ST_IDLE;
        end else begin
          i_nxt     = i_r + CW'(1);
          state_nxt = ST_DR_RI;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      n_r     <= '0;
      cap_r   <= tkfh_pkg::CAP_RESET;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      n_r     <= n_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) begin
        cap_r <= cfg_data;
      end
    end
    p_r     <= p_nxt;
    item_r  <= item_nxt;
    best_r  <= best_nxt;
    idata_r <= idata_nxt;
    bidx_r  <= bidx_nxt;
    bhas_r  <= bhas_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    ok_r    <= ok_nxt;
    ol_r    <= ol_nxt;
    okey_r  <= okey_nxt;
    oslot_r <= oslot_nxt;
    ocnt_r  <= ocnt_nxt;
  end

  assign out_valid       = ov_r;
  assign out_result_kind = ok_r;
  assign out_key         = okey_r;
  assign out_slot        = oslot_r;
  assign out_count       = ocnt_r;
  assign out_last        = ol_r;

endmodule

// ===== design/tkfh_checker.sv =====
// ----------------------------------------------------------------------------
// tkfh_checker
// Port-level checks on request and result sequencing of the heap unit.
// ----------------------------------------------------------------------------
`include "top_k_frequency_heap_unit_assert.svh"

module tkfh_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          in_req_type,
  input logic                          out_valid,
  input logic                          out_result_kind,
  input logic [tkfh_pkg::SLOT_W-1:0]   out_slot,
  input logic                          out_last
);

  // an accepted count request always makes the unit busy in the next cycle
  `TKH_ASSERT_NXT(a_count_busy, start && !busy && (in_req_type == tkfh_pkg::REQ_COUNT), busy)
  // ranked entries never carry a heap slot
  `TKH_ASSERT_IMP(a_rank_slot, out_valid && (out_result_kind == tkfh_pkg::KIND_RANK), out_slot == '1)
  // nothing follows the final result of a request by itself
  `TKH_ASSERT_NXT(a_last_gap, out_valid && out_last, !out_valid)
  // a result that is not the final one leaves the unit busy
  `TKH_ASSERT_IMP(a_mid_busy, out_valid && !out_last, busy)

endmodule

bind top_k_frequency_heap_unit tkfh_checker u_tkfh_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_req_type     (in_req_type),
  .out_valid       (out_valid),
  .out_result_kind (out_result_kind),
  .out_slot        (out_slot),
  .out_last        (out_last)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Top-k frequency heap unit testbench
// Drives count and drain requests through the start/busy handshake. A local
// heap model predicts every slot update and ranked entry, and the monitor
// compares each strobed result against the oldest prediction. Capacity is
// changed between phases, only while the unit is idle.
// ----------------------------------------------------------------------------
module tb;

  typedef struct {
    logic        kind;
    logic [63:0] key;
    logic [31:0] cnt;
    logic [5:0]  slot;
  } request_t;

  typedef struct {
    logic        kind;
    logic [63:0] key;
    logic [5:0]  slot;
    logic [31:0] cnt;
    logic        last;
  } heap_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_req_type = 1'b0;
  logic [63:0] in_word_key = '0;
  logic [31:0] in_word_count = '0;
  logic signed [5:0] in_held_slot = '0;
  logic out_valid, out_result_kind, out_last;
  logic [63:0] out_key;
  logic signed [5:0] out_slot;
  logic [31:0] out_count;
  logic cfg_we = 1'b0;
  logic [5:0] cfg_data = '0;

  top_k_frequency_heap_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_word_key(in_word_key),
    .in_word_count(in_word_count), .in_held_slot(in_held_slot),
    .out_valid(out_valid), .out_result_kind(out_result_kind),
    .out_key(out_key), .out_slot(out_slot), .out_count(out_count),
    .out_last(out_last), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Heap model state
  logic [31:0] mdl_cnt [tkfh_pkg::MAX_ENTRIES];
  logic [63:0] mdl_key [tkfh_pkg::MAX_ENTRIES];
  int          mdl_held;
  logic [5:0]  mdl_cap;

  request_t     pending_reqs[$];
  heap_result_t expected_results[$];
  int  errors = 0;
  int  n_results = 0;
  bit  idle_enable = 1'b1;
  int  gap_left = 0;
  bit  taken = 1'b0;

  // Word keys the stimulus keeps reusing, so held words and ties are common
  logic [63:0] vocab [16];

  function automatic bit nearer(int a, int b);
    if (mdl_cnt[a] != mdl_cnt[b]) return mdl_cnt[a] < mdl_cnt[b];
    return mdl_key[a] > mdl_key[b];
  endfunction

  function automatic void swap_slots(int a, int b);
    logic [31:0] c;
    logic [63:0] k;
    c = mdl_cnt[a]; k = mdl_key[a];
    mdl_cnt[a] = mdl_cnt[b]; mdl_key[a] = mdl_key[b];
    mdl_cnt[b] = c; mdl_key[b] = k;
  endfunction

  function automatic void push_result(logic kind, logic [63:0] key, int slot,
                                      logic [31:0] cnt);
    heap_result_t r;
    r.kind = kind; r.key = key; r.slot = 6'(slot); r.cnt = cnt; r.last = 1'b0;
    expected_results.push_back(r);
  endfunction

  function automatic int sift_down_mdl(int p);
    int l, r, m;
    forever begin
      l = 2 * p + 1; r = l + 1; m = p;
      if (l < mdl_held && nearer(l, m)) m = l;
      if (r < mdl_held && nearer(r, m)) m = r;
      if (m == p) break;
      swap_slots(p, m);
      push_result(tkfh_pkg::KIND_SLOT, mdl_key[p], p, mdl_cnt[p]);
      p = m;
    end
    return p;
  endfunction

  function automatic int sift_up_mdl(int p);
    int par;
    while (p > 0) begin
      par = (p - 1) / 2;
      if (!nearer(p, par)) break;
      swap_slots(p, par);
      push_result(tkfh_pkg::KIND_SLOT, mdl_key[p], p, mdl_cnt[p]);
      p = par;
    end
    return p;
  endfunction

  // Predict all results of one accepted request
  function automatic void predict_heap(request_t q);
    int n_prior, cap, p, best;
    n_prior = expected_results.size();
    cap = (mdl_cap < 1) ? 1 : (mdl_cap > tkfh_pkg::MAX_ENTRIES ?
                               tkfh_pkg::MAX_ENTRIES : int'(mdl_cap));
    if (q.kind == tkfh_pkg::REQ_DRAIN) begin
      for (int i = 0; i < mdl_held; i++) begin
        best = i;
        for (int j = i + 1; j < mdl_held; j++) if (nearer(best, j)) best = j;
        swap_slots(i, best);
        push_result(tkfh_pkg::KIND_RANK, mdl_key[i], -1, mdl_cnt[i]);
      end
      mdl_held = 0;
    end else if (!q.slot[5] && int'(q.slot) < mdl_held) begin
      p = q.slot;
      if (mdl_cnt[p] != 32'hFFFF_FFFF) mdl_cnt[p]++;
      p = sift_down_mdl(p);
      push_result(tkfh_pkg::KIND_SLOT, mdl_key[p], p, mdl_cnt[p]);
    end else if (mdl_held < cap) begin
      p = mdl_held;
      mdl_cnt[p] = q.cnt; mdl_key[p] = q.key;
      mdl_held++;
      p = sift_up_mdl(p);
      push_result(tkfh_pkg::KIND_SLOT, mdl_key[p], p, mdl_cnt[p]);
    end else if (q.cnt > mdl_cnt[0] || (q.cnt == mdl_cnt[0] && q.key < mdl_key[0])) begin
      push_result(tkfh_pkg::KIND_SLOT, mdl_key[0], -1, mdl_cnt[0]);
      mdl_cnt[0] = q.cnt; mdl_key[0] = q.key;
      p = sift_down_mdl(0);
      push_result(tkfh_pkg::KIND_SLOT, mdl_key[p], p, mdl_cnt[p]);
    end else begin
      push_result(tkfh_pkg::KIND_SLOT, q.key, -1, 32'd0);
    end
    if (expected_results.size() > n_prior)
      expected_results[expected_results.size() - 1].last = 1'b1;
  endfunction

  // Driver: falling edge, random gaps between requests
  always @(negedge clk) begin
    if (rst_n) begin
      if (!start || taken) begin
        if (gap_left > 0) begin
          start    <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (taken && idle_enable && $urandom_range(0, 2) == 0) begin
          // this cycle is the first of the gap
          start    <= 1'b0;
          gap_left <= $urandom_range(0, 17);
        end else if (pending_reqs.size() > 0) begin
          in_req_type   <= pending_reqs[0].kind;
          in_word_key   <= pending_reqs[0].key;
          in_word_count <= pending_reqs[0].cnt;
          in_held_slot  <= pending_reqs[0].slot;
          start         <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Acceptance is seen at the rising edge; it retires the driven request
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      predict_heap(pending_reqs[0]);
      void'(pending_reqs.pop_front());
      taken <= 1'b1;
    end else begin
      taken <= 1'b0;
    end
  end

  // Monitor: compare each strobed result with the oldest prediction
  always @(posedge clk) begin
    heap_result_t e;
    if (rst_n && out_valid) begin
      n_results++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result key=%h slot=%0d count=%0d", $realtime,
                 out_key, out_slot, out_count);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_result_kind !== e.kind || out_key !== e.key || out_slot !== e.slot ||
            out_count !== e.cnt || out_last !== e.last) begin
          $display("%0t: mismatch expected kind=%0d key=%h slot=%0d count=%0d last=%0d",
                   $realtime, e.kind, e.key, $signed(e.slot), e.cnt, e.last);
          $display("%0t:          actual   kind=%0d key=%h slot=%0d count=%0d last=%0d",
                   $realtime, out_result_kind, out_key, out_slot, out_count, out_last);
          errors++;
        end
      end
    end
  end

  function automatic request_t count_req(logic [63:0] key, logic [31:0] cnt,
                                         logic [5:0] slot);
    request_t q;
    q.kind = tkfh_pkg::REQ_COUNT; q.key = key; q.cnt = cnt; q.slot = slot;
    return q;
  endfunction

  function automatic request_t drain_req();
    request_t q;
    q.kind = tkfh_pkg::REQ_DRAIN; q.key = {$urandom, $urandom}; q.cnt = $urandom;
    q.slot = 6'($urandom);
    return q;
  endfunction

  // Wait until every request is taken and every result has come back
  task automatic wait_idle();
    while (pending_reqs.size() > 0 || start || expected_results.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_capacity(logic [5:0] v);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    mdl_cap = v;
  endtask

  // Random phase: mostly reused words with a random slot or none, some noise
  task automatic random_phase(int n);
    request_t q;
    int r, s;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 5) q = drain_req();
      else begin
        s = $urandom_range(0, 9) < 6 ? $urandom_range(0, 31) : -1;
        if (r < 15) s = $urandom_range(0, 63);
        q = count_req(r < 80 ? vocab[$urandom_range(0, 15)] : {$urandom, $urandom},
                      $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 12),
                      6'(s));
      end
      pending_reqs.push_back(q);
    end
    wait_idle();
  endtask

  initial begin
    mdl_held = 0;
    mdl_cap = tkfh_pkg::CAP_RESET;
    for (int i = 0; i < tkfh_pkg::MAX_ENTRIES; i++) begin
      mdl_cnt[i] = '0; mdl_key[i] = '0;
    end
    for (int i = 0; i < 16; i++) vocab[i] = {$urandom, $urandom};
    vocab[0] = 64'h0; vocab[1] = '1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty drain, field extremes, ties, saturation, held bumps
    pending_reqs.push_back(drain_req());
    pending_reqs.push_back(count_req(64'h0, 32'h0, 6'h3F));
    pending_reqs.push_back(count_req('1, 32'hFFFF_FFFF, 6'h3F));
    pending_reqs.push_back(count_req(64'h5, 32'h0, 6'd31));
    pending_reqs.push_back(count_req(64'h7, 32'h0, 6'h20));
    pending_reqs.push_back(count_req(64'h9, 32'd5, 6'h3F));
    pending_reqs.push_back(count_req(64'h0, 32'd0, 6'd0));
    pending_reqs.push_back(count_req(64'h0, 32'd0, 6'd1));
    pending_reqs.push_back(drain_req());
    wait_idle();
    // Saturating bump: slot 0 is the only entry
    pending_reqs.push_back(count_req('1, 32'hFFFF_FFFF, 6'h3F));
    pending_reqs.push_back(count_req('1, 32'h0, 6'd0));
    wait_idle();
    // Tiny heap: capacity 0 acts as one, eviction and rejection
    write_capacity(6'd0);
    pending_reqs.push_back(count_req(64'h11, 32'd3, 6'h3F));
    pending_reqs.push_back(count_req(64'h10, 32'd3, 6'h3F));
    pending_reqs.push_back(count_req(64'h12, 32'd3, 6'h3F));
    pending_reqs.push_back(count_req(64'h13, 32'd1, 6'h3F));
    pending_reqs.push_back(drain_req());
    wait_idle();

    // Random phases through several capacities
    write_capacity(6'd4);
    random_phase(20);
    write_capacity(6'd63);
    random_phase(30);
    write_capacity(6'd2);
    random_phase(15);
    write_capacity(6'd32);
    idle_enable = 1'b0;
    random_phase(30);
    pending_reqs.push_back(drain_req());
    wait_idle();

    $display("Ran directed extremes plus random count and drain requests, %0d results",
             n_results);
    $display("checked across capacities 0, 2, 4, 32 and 63.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end
endmodule
